[src/windowed_imu_linear_classifier_core_macros.svh]
// assertion helpers shared by the classifier rtl
`ifndef WINDOWED_IMU_LINEAR_CLASSIFIER_CORE_MACROS_SVH
`define WINDOWED_IMU_LINEAR_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define WIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define WIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/wic_pkg.sv]
package wic_pkg;

  // defaults for the top-level parameters
  localparam int SEGMENTS_DEF  = 5;
  localparam int FEAT_FRAC_DEF = 8;

  // fixed field and storage widths
  localparam int SLOTS    = 6;
  localparam int SLOT_W   = 3;
  localparam int RAW_W    = 16;
  localparam int FEAT_W   = 32;
  localparam int WEIGHT_W = 24;
  localparam int CNT_W    = 16;
  localparam int DELTA_W  = 9;
  localparam int CMD_W    = 2;
  localparam int GYRO_W   = 24;

  // reading scale factors
  localparam int ACCEL_SHIFT = 14;
  localparam int GYRO_MUL    = 250;
  localparam int GYRO_SHIFT  = 15;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMP,
    ST_AVG_RD,
    ST_AVG_DAT,
    ST_AVG_DIV,
    ST_DOT,
    ST_FIN
  } state_t;

  // feature memory control bits
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } fm_ctl_t;

  // accel / 16384, truncated toward zero
  function automatic logic signed [DELTA_W-1:0] accel_scale(input logic signed [RAW_W-1:0] a);
    logic signed [RAW_W-1:0] t;
    t = a + (a[RAW_W-1] ? RAW_W'((1 << ACCEL_SHIFT) - 1) : RAW_W'(0));
    return DELTA_W'(t >>> ACCEL_SHIFT);
  endfunction

  // gyro * 250 / 32768, truncated toward zero, wide intermediate
  function automatic logic signed [DELTA_W-1:0] gyro_scale(input logic signed [RAW_W-1:0] g);
    logic signed [GYRO_W-1:0] p;
    logic signed [GYRO_W-1:0] t;
    p = GYRO_W'(g) * GYRO_W'(GYRO_MUL);
    t = p + (p[GYRO_W-1] ? GYRO_W'((1 << GYRO_SHIFT) - 1) : GYRO_W'(0));
    return DELTA_W'(t >>> GYRO_SHIFT);
  endfunction

endpackage

[src/wic_feat_mem.sv]
module wic_feat_mem
  import wic_pkg::*;
#(
  parameter int DEPTH = SEGMENTS_DEF * SLOTS,
  parameter int AW    = $clog2(SEGMENTS_DEF * SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  fm_ctl_t           ctl,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  input  logic [FEAT_W-1:0] wr_data,
  input  logic [AW-1:0]     clr_base,
  output logic [FEAT_W-1:0] rd_data
);

  logic [FEAT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [FEAT_W-1:0] rd_q;
  logic              rd_vld;

  // storage array and registered read
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_q   <= mem[rd_addr];
      rd_vld <= valid[rd_addr];
    end
  end

  // valid bits: cleared by reset and by a segment clear
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctl.wr) begin
        valid[wr_addr] <= 1'b1;
      end
      if (ctl.clr) begin
        for (int e = 0; e < DEPTH; e++) begin
          if (AW'(e) >= clr_base && AW'(e) < clr_base + AW'(SLOTS)) begin
            valid[e] <= 1'b0;
          end
        end
      end
    end
  end

  // an entry never written since its clear reads as zero
  assign rd_data = rd_vld ? rd_q : '0;

endmodule

[src/wic_weight_mem.sv]
module wic_weight_mem
  import wic_pkg::*;
#(
  parameter int DEPTH = 2 * SEGMENTS_DEF * SLOTS,
  parameter int AW    = $clog2(2 * SEGMENTS_DEF * SLOTS)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [WEIGHT_W-1:0] wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output logic [WEIGHT_W-1:0] rdata
);

  logic [WEIGHT_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/wic_div.sv]
module wic_div
  import wic_pkg::*;
#(
  parameter int FRAC = FEAT_FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FEAT_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [FEAT_W-1:0] quotient
);

  localparam int NW = FEAT_W + FRAC;
  localparam int CW = $clog2(NW + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [NW-1:0]     q;
  logic              neg;
  logic [FEAT_W-1:0] mag;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              fits;

  // magnitude of the signed sum
  assign mag = dividend[FEAT_W-1] ? (~dividend + FEAT_W'(1)) : dividend;

  // one restoring step per cycle
  assign rem_sh = {rem, q[NW-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign fits   = ~diff[CNT_W];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= NW'(mag) << FRAC;
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[FEAT_W-1];
    end else if (busy) begin
      rem <= fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      q   <= {q[NW-2:0], fits};
    end
  end

  // truncate toward zero, keep the low word
  assign quotient = neg ? (~q[FEAT_W-1:0] + FEAT_W'(1)) : q[FEAT_W-1:0];

endmodule

[src/windowed_imu_linear_classifier_core.sv]
// channel | handshake            | word
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_ready  | command, accel_x/y/z, gyro_x/y/z, weight_class,
//         |                      | weight_index, weight_value
// out     | out_valid / out_ready| is_forehand, is_drive (one word per close)
//
// Sample: accept, then read-add-write of the six slots of the open segment; a sample
// taken while the count is saturated is dropped. Load and unused commands: the accept
// alone. Close: the bit-per-cycle divider averages each slot, then the single
// multiply-accumulate runs over both weight vectors. Reset (rst, synchronous) clears
// the feature valid bits at once. A result waiting on out_ready does not block samples
// or loads; a later close holds in its last cycle until the output register is free.
`include "windowed_imu_linear_classifier_core_macros.svh"

module windowed_imu_linear_classifier_core
  import wic_pkg::*;
#(
  parameter int SEGMENTS  = SEGMENTS_DEF,
  parameter int FEAT_FRAC = FEAT_FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CMD_W-1:0]           command,
  input  logic signed [RAW_W-1:0]    accel_x,
  input  logic signed [RAW_W-1:0]    accel_y,
  input  logic signed [RAW_W-1:0]    accel_z,
  input  logic signed [RAW_W-1:0]    gyro_x,
  input  logic signed [RAW_W-1:0]    gyro_y,
  input  logic signed [RAW_W-1:0]    gyro_z,
  input  logic                       weight_class,
  input  logic [4:0]                 weight_index,
  input  logic signed [WEIGHT_W-1:0] weight_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       is_forehand,
  output logic                       is_drive
);

  localparam int FEATURES = SEGMENTS * SLOTS;
  localparam int FAW      = $clog2(FEATURES);
  localparam int WDEPTH   = 2 * FEATURES;
  localparam int WAW      = $clog2(WDEPTH);
  localparam int PROD_W   = FEAT_W + WEIGHT_W;
  localparam int ACC_W    = PROD_W + WAW + 1;

  state_t state;
  state_t state_next;

  logic [FAW-1:0]            seg_base;
  logic [FAW-1:0]            base_next;
  logic [CNT_W-1:0]          sample_count;
  logic [SLOT_W-1:0]         slot;
  logic signed [DELTA_W-1:0] delta [SLOTS];
  logic                      accept;
  logic                      last_slot;
  logic                      avg_wr;

  // feature and weight memory hookup
  fm_ctl_t             fm_ctl;
  logic [FAW-1:0]      fm_rd_addr;
  logic [FAW-1:0]      fm_wr_addr;
  logic [FEAT_W-1:0]   fm_wr_data;
  logic [FEAT_W-1:0]   fm_rd_data;
  logic                wm_we;
  logic [WAW-1:0]      wm_waddr;
  logic                wm_re;
  logic [WEIGHT_W-1:0] wm_rd_data;

  // divider hookup
  logic              div_start;
  logic              div_done;
  logic [FEAT_W-1:0] div_quot;

  // dot product pipeline
  logic [FAW-1:0]            fptr;
  logic [WAW-1:0]            wptr;
  logic                      issue_en;
  logic                      issue;
  logic                      l0, c0, v1, l1, c1, v2, l2, c2;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_sum;
  logic                      fh_bit;
  logic                      dr_bit;
  logic                      out_free;

  assign accept    = in_valid && in_ready;
  assign last_slot = (slot == SLOT_W'(SLOTS - 1));
  assign base_next = (seg_base == FAW'(FEATURES - SLOTS)) ? '0 : seg_base + FAW'(SLOTS);
  assign avg_wr    = (state == ST_AVG_DAT && sample_count == '0) ||
                     (state == ST_AVG_DIV && div_done);
  assign issue     = (state == ST_DOT) && issue_en;
  assign l0        = (wptr == WAW'(FEATURES - 1)) || (wptr == WAW'(WDEPTH - 1));
  assign c0        = (wptr >= WAW'(FEATURES));
  assign acc_sum   = acc + ACC_W'(prod);
  assign out_free  = !out_valid || out_ready;

  wic_feat_mem #(
    .DEPTH (FEATURES),
    .AW    (FAW)
  ) u_feat_mem (
    .clk      (clk),
    .rst      (rst),
    .ctl      (fm_ctl),
    .rd_addr  (fm_rd_addr),
    .wr_addr  (fm_wr_addr),
    .wr_data  (fm_wr_data),
    .clr_base (seg_base),
    .rd_data  (fm_rd_data)
  );

  wic_weight_mem #(
    .DEPTH (WDEPTH),
    .AW    (WAW)
  ) u_weight_mem (
    .clk   (clk),
    .we    (wm_we),
    .waddr (wm_waddr),
    .wdata (weight_value),
    .re    (wm_re),
    .raddr (wptr),
    .rdata (wm_rd_data)
  );

  wic_div #(
    .FRAC (FEAT_FRAC)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (fm_rd_data),
    .divisor  (sample_count),
    .done     (div_done),
    .quotient (div_quot)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (command == CMD_SAMPLE && sample_count != CNT_MAX) begin
            state_next = ST_SMP;
          end else if (command == CMD_CLOSE) begin
            state_next = ST_AVG_RD;
          end
        end
      end
      ST_SMP: begin
        if (slot == SLOT_W'(SLOTS)) state_next = ST_IDLE;
      end
      ST_AVG_RD: state_next = ST_AVG_DAT;
      ST_AVG_DAT: begin
        if (sample_count != '0) begin
          state_next = ST_AVG_DIV;
        end else begin
          state_next = last_slot ? ST_DOT : ST_AVG_RD;
        end
      end
      ST_AVG_DIV: begin
        if (div_done) state_next = last_slot ? ST_DOT : ST_AVG_RD;
      end
      ST_DOT: begin
        if (v2 && l2 && c2) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory, divider and handshake controls
  always_comb begin
    in_ready   = (state == ST_IDLE);
    fm_ctl     = '0;
    fm_rd_addr = seg_base + FAW'(slot);
    fm_wr_addr = seg_base + FAW'(slot);
    fm_wr_data = div_quot;
    wm_we      = 1'b0;
    wm_waddr   = WAW'(weight_index) + (weight_class ? WAW'(FEATURES) : WAW'(0));
    wm_re      = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        wm_we = in_valid && command == CMD_LOAD &&
                (32'(weight_index) < 32'(FEATURES));
      end
      ST_SMP: begin
        fm_ctl.rd  = (slot < SLOT_W'(SLOTS));
        fm_ctl.wr  = (slot != '0);
        fm_wr_addr = seg_base + FAW'(slot) - FAW'(1);
        fm_wr_data = fm_rd_data + FEAT_W'(delta[slot - SLOT_W'(1)]);
      end
      ST_AVG_RD: fm_ctl.rd = 1'b1;
      ST_AVG_DAT: begin
        div_start  = (sample_count != '0);
        fm_ctl.wr  = avg_wr;
        fm_wr_data = '0;
      end
      ST_AVG_DIV: fm_ctl.wr = avg_wr;
      ST_DOT: begin
        fm_ctl.rd  = issue;
        fm_rd_addr = fptr;
        wm_re      = issue;
      end
      ST_FIN: fm_ctl.clr = out_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      seg_base     <= '0;
      sample_count <= '0;
      slot         <= '0;
      issue_en     <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      // sequencing of the open segment
      if (accept) begin
        slot <= '0;
        if (command == CMD_SAMPLE && sample_count != CNT_MAX) begin
          sample_count <= sample_count + CNT_W'(1);
        end
      end else if (state == ST_SMP) begin
        slot <= slot + SLOT_W'(1);
      end else if (avg_wr) begin
        slot <= slot + SLOT_W'(1);
        if (last_slot) begin
          seg_base     <= base_next;
          sample_count <= '0;
          issue_en     <= 1'b1;
        end
      end
      // stop issuing after the last weight
      if (issue && wptr == WAW'(WDEPTH - 1)) begin
        issue_en <= 1'b0;
      end
      // output word
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && command == CMD_SAMPLE) begin
      delta[0] <= accel_scale(accel_x);
      delta[1] <= accel_scale(accel_y);
      delta[2] <= accel_scale(accel_z);
      delta[3] <= gyro_scale(gyro_x);
      delta[4] <= gyro_scale(gyro_y);
      delta[5] <= gyro_scale(gyro_z);
    end
    // pointers start at the oldest segment once averaging ends
    if (avg_wr && last_slot) begin
      fptr <= base_next;
      wptr <= '0;
      acc  <= '0;
    end else if (issue) begin
      fptr <= (fptr == FAW'(FEATURES - 1)) ? '0 : fptr + FAW'(1);
      wptr <= wptr + WAW'(1);
    end
    l1   <= l0;
    c1   <= c0;
    l2   <= l1;
    c2   <= c1;
    prod <= $signed(fm_rd_data) * $signed(wm_rd_data);
    // accumulate, latch sign at each vector end
    if (v2) begin
      if (l2) begin
        acc <= '0;
        if (c2) begin
          dr_bit <= (acc_sum > 0);
        end else begin
          fh_bit <= (acc_sum > 0);
        end
      end else begin
        acc <= acc_sum;
      end
    end
    if (state == ST_FIN && out_free) begin
      is_forehand <= fh_bit;
      is_drive    <= dr_bit;
    end
  end

  `WIC_ASSERT_IMP(a_fm_no_clash, fm_ctl.rd && fm_ctl.wr, fm_rd_addr != fm_wr_addr, "feature read and write hit one entry")
  `WIC_ASSERT_IMP(a_div_nonzero, div_start, sample_count != '0, "divider started with zero count")
  `WIC_ASSERT_IMP(a_base_range, 1'b1, seg_base <= FAW'(FEATURES - SLOTS), "segment base out of range")
  `WIC_ASSERT_NXT(a_fin_out, state == ST_FIN && out_free, out_valid && state == ST_IDLE, "close finished without a word")

endmodule

[tb/windowed_imu_linear_classifier_core_tb.sv]
module windowed_imu_linear_classifier_core_tb;
  import wic_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 11;
  localparam int SEGS            = SEGMENTS_DEF;
  localparam int FEATS           = SEGS * SLOTS;
  localparam int RANDOM_WORDS    = 300;
  localparam int LONG_HOLD       = 1500;
  localparam int TAIL_CYCLES     = 400;
  localparam int WATCHDOG_CYCLES = 4_000_000;
  localparam int MAX_REPORTS     = 50;

  localparam logic [CMD_W-1:0]           CMD_SPARE = 2'd3;
  localparam logic signed [RAW_W-1:0]    RAW_MAX   = 16'sh7fff;
  localparam logic signed [RAW_W-1:0]    RAW_MIN   = 16'sh8000;
  localparam logic signed [WEIGHT_W-1:0] W_ONE     = 24'sd4096;  // 1.0 in q11.12
  localparam logic signed [WEIGHT_W-1:0] W_MAX     = 24'sh7fffff;
  localparam logic signed [WEIGHT_W-1:0] W_MIN     = 24'sh800000;

  // one input word; raw[0..2] accel x/y/z, raw[3..5] gyro x/y/z
  typedef struct packed {
    logic [CMD_W-1:0]            cmd;
    logic [SLOTS-1:0][RAW_W-1:0] raw;
    logic                        wcls;
    logic [4:0]                  widx;
    logic [WEIGHT_W-1:0]         wval;
  } imu_word_t;

  typedef struct packed {
    logic fh;
    logic dr;
  } stroke_t;

  typedef struct packed {
    imu_word_t   w;
    logic [16:0] reps;
    logic        chk;
    stroke_t     res;
  } dir_row_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic [CMD_W-1:0]           command;
  logic signed [RAW_W-1:0]    accel_x;
  logic signed [RAW_W-1:0]    accel_y;
  logic signed [RAW_W-1:0]    accel_z;
  logic signed [RAW_W-1:0]    gyro_x;
  logic signed [RAW_W-1:0]    gyro_y;
  logic signed [RAW_W-1:0]    gyro_z;
  logic                       weight_class;
  logic [4:0]                 weight_index;
  logic signed [WEIGHT_W-1:0] weight_value;
  logic                       out_valid;
  logic                       out_ready;
  logic                       is_forehand;
  logic                       is_drive;

  // predictor state
  logic signed [FEAT_W-1:0]   feat_mem [FEATS] = '{default: '0};
  logic signed [WEIGHT_W-1:0] wgt_mem [2*FEATS] = '{default: '0};
  int unsigned                smp_cnt = 0;
  int unsigned                seg_ptr = 0;

  stroke_t  stroke_q [$];
  dir_row_t dir_rows [$];
  int       mismatch_count = 0;
  bit       idle_en = 1'b1;
  int       ready_hold = 0;
  int       long_hold_left = 0;
  bit       result_seen = 1'b0;

  windowed_imu_linear_classifier_core DUT (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
  endtask

  // word builders
  function automatic imu_word_t mk_sample(input logic signed [RAW_W-1:0] ax, ay, az, gx, gy, gz);
    imu_word_t w;
    w = '0;
    w.cmd = CMD_SAMPLE;
    w.raw = {gz, gy, gx, az, ay, ax};
    return w;
  endfunction

  function automatic imu_word_t mk_cmd(input logic [CMD_W-1:0] cmd);
    imu_word_t w;
    w = '0;
    w.cmd = cmd;
    return w;
  endfunction

  function automatic imu_word_t mk_load(input logic cls, input logic [4:0] idx,
                                        input logic signed [WEIGHT_W-1:0] val);
    imu_word_t w;
    w = '0;
    w.cmd = CMD_LOAD;
    w.wcls = cls;
    w.widx = idx;
    w.wval = val;
    return w;
  endfunction

  // all fields but the command random, readings biased toward the extremes
  function automatic imu_word_t rand_word(input logic [CMD_W-1:0] cmd);
    imu_word_t w;
    int k;
    w.cmd = cmd;
    for (k = 0; k < SLOTS; k++) begin
      case ($urandom_range(0, 7))
        0: w.raw[k] = RAW_MAX;
        1: w.raw[k] = RAW_MIN;
        default: w.raw[k] = RAW_W'($urandom);
      endcase
    end
    w.wcls = 1'($urandom);
    w.widx = 5'($urandom_range(0, 31));
    w.wval = WEIGHT_W'($urandom);
    return w;
  endfunction

  function automatic dir_row_t dir_row(input imu_word_t w, input int reps = 1,
                                       input bit chk = 1'b0, input bit fh = 1'b0,
                                       input bit dr = 1'b0);
    dir_row_t r;
    r.w = w;
    r.reps = 17'(reps);
    r.chk = chk;
    r.res.fh = fh;
    r.res.dr = dr;
    return r;
  endfunction

  // stroke predictor: updates the ring and weights, returns the class bits of a close
  task automatic predict_stroke(input imu_word_t w, output bit has_res, output stroke_t res);
    int k, i, base, pos;
    longint d, avg, acc0, acc1;
    logic signed [RAW_W-1:0] rd;
    has_res = 1'b0;
    res = '0;
    base = seg_ptr * SLOTS;
    case (w.cmd)
      CMD_SAMPLE: begin
        // count saturated readings are dropped
        if (smp_cnt < CNT_MAX) begin
          for (k = 0; k < SLOTS; k++) begin
            rd = w.raw[k];
            if (k < 3) d = longint'(rd) / (longint'(1) << ACCEL_SHIFT);
            else d = (longint'(rd) * GYRO_MUL) / (longint'(1) << GYRO_SHIFT);
            feat_mem[base + k] = feat_mem[base + k] + d;
          end
          smp_cnt++;
        end
      end
      CMD_LOAD: begin
        if (w.widx < FEATS) wgt_mem[w.wcls * FEATS + w.widx] = w.wval;
      end
      CMD_CLOSE: begin
        // sums to averages, zero when the segment saw no readings
        for (k = 0; k < SLOTS; k++) begin
          avg = 0;
          if (smp_cnt != 0)
            avg = (longint'(feat_mem[base + k]) * (longint'(1) << FEAT_FRAC_DEF)) /
                  longint'(smp_cnt);
          feat_mem[base + k] = avg[FEAT_W-1:0];
        end
        smp_cnt = 0;
        seg_ptr = (seg_ptr + 1) % SEGS;
        base = seg_ptr * SLOTS;
        // dot products, oldest segment first
        acc0 = 0;
        acc1 = 0;
        for (i = 0; i < FEATS; i++) begin
          pos = (base + i) % FEATS;
          acc0 += longint'(feat_mem[pos]) * longint'(wgt_mem[i]);
          acc1 += longint'(feat_mem[pos]) * longint'(wgt_mem[FEATS + i]);
        end
        for (k = 0; k < SLOTS; k++) feat_mem[base + k] = '0;
        has_res = 1'b1;
        res.fh = (acc0 > 0);
        res.dr = (acc1 > 0);
      end
      default: ;
    endcase
  endtask

  // offer one word after a random gap when gaps are enabled, predict once it is taken
  task automatic send_word(input imu_word_t w, input bit chk = 1'b0, input stroke_t typed = '0);
    int gap;
    bit has_res;
    stroke_t res;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    command      <= w.cmd;
    accel_x      <= w.raw[0];
    accel_y      <= w.raw[1];
    accel_z      <= w.raw[2];
    gyro_x       <= w.raw[3];
    gyro_y       <= w.raw[4];
    gyro_z       <= w.raw[5];
    weight_class <= w.wcls;
    weight_index <= w.widx;
    weight_value <= w.wval;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_stroke(w, has_res, res);
    if (has_res) stroke_q.push_back(chk ? typed : res);
  endtask

  // stop offering, then wait for every expected word
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (stroke_q.size() != 0) @(posedge clk);
  endtask

  // receiver: long hold-off, else a per-word stall once a result shows up
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (result_seen && ready_hold > 0) ready_hold--;
        out_ready <= (ready_hold == 0);
      end
    end
  end

  // result checker
  always @(posedge clk) begin : check_words
    stroke_t e;
    result_seen = out_valid && !rst;
    if (!rst && out_valid && out_ready) begin
      if (stroke_q.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        e = stroke_q.pop_front();
        if (is_forehand !== e.fh)
          report_mismatch($sformatf("is_forehand %b, expected %b", is_forehand, e.fh));
        if (is_drive !== e.dr)
          report_mismatch($sformatf("is_drive %b, expected %b", is_drive, e.dr));
      end
      ready_hold = idle_en ? $urandom_range(0, 3) : 0;
    end
  end

  // stimulus
  initial begin
    int i, n, sent, pick;
    imu_word_t w;
    rst          = 1'b1;
    in_valid     = 1'b0;
    command      = CMD_SAMPLE;
    accel_x      = '0;
    accel_y      = '0;
    accel_z      = '0;
    gyro_x       = '0;
    gyro_y       = '0;
    gyro_z       = '0;
    weight_class = 1'b0;
    weight_index = '0;
    weight_value = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // known weight sets: class 0 all +1.0, class 1 all -1.0
    for (i = 0; i < FEATS; i++) begin
      send_word(mk_load(1'b0, 5'(i), W_ONE));
      send_word(mk_load(1'b1, 5'(i), -W_ONE));
    end

    dir_rows = '{
      // readings just under one step truncate to zero deltas
      dir_row(mk_sample(16383, -16383, 0, 131, -131, 0), 4),
      dir_row(mk_cmd(CMD_CLOSE), 1, 1'b1, 1'b0, 1'b0),
      // close with no readings
      dir_row(mk_cmd(CMD_CLOSE), 1, 1'b1, 1'b0, 1'b0),
      // single max reading: positive features
      dir_row(mk_sample(RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX)),
      dir_row(mk_cmd(CMD_CLOSE), 1, 1'b1, 1'b1, 1'b0),
      // min and truncation edges, uneven division
      dir_row(mk_sample(RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN)),
      dir_row(mk_sample(16384, -16384, -16385, 132, -132, -32767)),
      dir_row(mk_sample(-1, 1, RAW_MAX, -1, 1, RAW_MIN)),
      dir_row(mk_cmd(CMD_CLOSE)),
      // spare command and out-of-range weight indexes are ignored
      dir_row(mk_cmd(CMD_SPARE)),
      dir_row(mk_load(1'b1, 5'd30, 24'sd1234)),
      dir_row(mk_load(1'b0, 5'd31, -24'sd1)),
      // weight extremes
      dir_row(mk_load(1'b0, 5'd0, W_MIN)),
      dir_row(mk_load(1'b1, 5'd29, W_MAX)),
      dir_row(mk_load(1'b0, 5'd15, 24'sd0)),
      // walk the ring past its wrap
      dir_row(mk_sample(RAW_MAX, RAW_MIN, RAW_MAX, RAW_MIN, RAW_MAX, RAW_MIN)),
      dir_row(mk_cmd(CMD_CLOSE)),
      dir_row(mk_cmd(CMD_CLOSE)),
      dir_row(mk_cmd(CMD_CLOSE)),
      dir_row(mk_sample(RAW_MIN, RAW_MAX, RAW_MIN, RAW_MAX, RAW_MIN, RAW_MAX)),
      dir_row(mk_cmd(CMD_CLOSE)),
      dir_row(mk_cmd(CMD_CLOSE))
    };

    foreach (dir_rows[ri]) begin
      idle_en = (dir_rows[ri].reps == 1);
      repeat (dir_rows[ri].reps) send_word(dir_rows[ri].w, dir_rows[ri].chk, dir_rows[ri].res);
    end
    idle_en = 1'b1;

    // receiver holds off while closes pile up behind the output register
    long_hold_left = LONG_HOLD;
    repeat (3) begin
      repeat (2) send_word(rand_word(CMD_SAMPLE));
      send_word(rand_word(CMD_CLOSE));
    end
    wait_drained();

    // random segments with loads, spare commands and idle changes mixed in
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        repeat (n) send_word(rand_word(CMD_SAMPLE));
        send_word(rand_word(CMD_CLOSE));
        sent += n + 1;
      end else if (pick < 17) begin
        w = rand_word(CMD_LOAD);
        send_word(w);
        if (w.widx < FEATS) sent++;
      end else if (pick == 17) begin
        send_word(rand_word(CMD_SPARE));
      end else if (pick == 18) begin
        idle_en = ($urandom_range(0, 3) != 0);
      end else begin
        wait_drained();
      end
    end

    // drain and settle
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (stroke_q.size() != 0) report_mismatch("expected result words never arrived");
    if (mismatch_count == 0) begin
      $display("** windowed_imu_linear_classifier_core: PASSED **");
    end else begin
      $display("** windowed_imu_linear_classifier_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(CLK_PERIOD * WATCHDOG_CYCLES);
    $display("** windowed_imu_linear_classifier_core: FAILED **");
    $finish;
  end

endmodule
